// ===== hdl/aecf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecf_pkg
// Shared types and constants of the envelope command chaining framer.
// ----------------------------------------------------------------------------
package aecf_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_FRAGMENT  = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_RESP = 2'd1;
  localparam logic [1:0] CFG_EXT_ALLOWED   = 2'd2;

  // command header codes
  localparam logic [7:0] CLA_CHAINED  = 8'h10;
  localparam logic [7:0] CLA_LAST     = 8'h00;
  localparam logic [7:0] INS_ENVELOPE = 8'hC3;
  localparam logic [7:0] P_ZERO       = 8'h00;

  // length limits
  localparam logic [15:0] SHORT_LC_MAX = 16'd255;
  localparam logic [16:0] SHORT_LE_MAX = 17'd256;
  localparam logic [16:0] EXT_LE_MAX   = 17'd65536;

  // configuration register file
  typedef struct packed {
    logic [15:0] max_fragment_bytes;
    logic [16:0] expected_response_bytes;
    logic        extended_allowed;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [7:0]  data;      // message byte
    logic        hdr;       // open a command before the data byte
    logic        err;       // extended length refused
    logic        fin;       // command is the last of the chain
    logic        ext;       // command uses extended lengths
    logic [15:0] frag;      // Lc value of an opened command
    logic        closing;   // data byte closes the command
    logic [15:0] le_code;   // coded Le, low byte used when short
  } job_t;

endpackage

// ===== hdl/aecf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecf_front
// Accepts message bytes, tracks offset and fragment state, and classifies
// each item into a job for the back end.
// ----------------------------------------------------------------------------
module aecf_front import aecf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic [15:0] in_message_length,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  logic [15:0] offset_r, offset_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        fin_r, fin_nxt;
  logic        ext_r, ext_nxt;
  logic        disc_r, disc_nxt;

  logic        accept;
  logic [15:0] len, off, rem, avail, maxf, frag, rem_c, rem_dec;
  logic [16:0] le0, le_eff;
  logic        restart, disc, open, fin, ext, err, fin_c, ext_c, last, closing;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // effective Le from the registers
  always_comb begin
    le0    = (cfg.expected_response_bytes == 17'd0) ? 17'd1 : cfg.expected_response_bytes;
    le_eff = (le0 > EXT_LE_MAX) ? EXT_LE_MAX : le0;
  end

  // classify the item against the current fragment
  always_comb begin
    len     = (in_message_length == 16'd0) ? 16'd1 : in_message_length;
    restart = offset_r >= len;
    off     = restart ? 16'd0 : offset_r;
    rem     = restart ? 16'd0 : rem_r;
    disc    = restart ? 1'b0 : disc_r;
    open    = !disc && (rem == 16'd0);
    maxf    = (cfg.max_fragment_bytes == 16'd0) ? 16'd1 : cfg.max_fragment_bytes;
    avail   = len - off;
    fin     = avail <= maxf;
    frag    = fin ? avail : maxf;
    ext     = (frag > SHORT_LC_MAX) || (fin && (le_eff > SHORT_LE_MAX));
    err     = open && ext && !cfg.extended_allowed;
    fin_c   = open ? fin : fin_r;
    ext_c   = open ? ext : ext_r;
    rem_c   = open ? frag : rem;
    rem_dec = rem_c - 16'd1;
    last    = (off == len - 16'd1);
    closing = (rem_dec == 16'd0) || last;
  end

  // job for the queue
  always_comb begin
    push        = accept && !disc;
    job.data    = in_message_byte;
    job.hdr     = open && !err;
    job.err     = err;
    job.fin     = fin_c;
    job.ext     = ext_c;
    job.frag    = frag;
    job.closing = closing;
    job.le_code = le_eff[15:0];
  end

  // next fragment state
  always_comb begin
    offset_nxt = offset_r;
    rem_nxt    = rem_r;
    fin_nxt    = fin_r;
    ext_nxt    = ext_r;
    disc_nxt   = disc_r;
    if (accept) begin
      if (open && !err) begin
        fin_nxt = fin;
        ext_nxt = ext;
      end
      if (last) begin
        offset_nxt = 16'd0;
        rem_nxt    = 16'd0;
        disc_nxt   = 1'b0;
      end else begin
        offset_nxt = off + 16'd1;
        disc_nxt   = disc || err;
        rem_nxt    = (disc || err) ? rem : (closing ? 16'd0 : rem_dec);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 16'd0;
      rem_r    <= 16'd0;
      fin_r    <= 1'b0;
      ext_r    <= 1'b0;
      disc_r   <= 1'b0;
    end else begin
      offset_r <= offset_nxt;
      rem_r    <= rem_nxt;
      fin_r    <= fin_nxt;
      ext_r    <= ext_nxt;
      disc_r   <= disc_nxt;
    end
  end

endmodule

// ===== hdl/aecf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecf_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module aecf_queue import aecf_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign empty   = (count_r == CW'(0));
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== hdl/aecf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecf_back
// Expands each job into command bytes, one per cycle while out_stall is low,
// into the output register.
// ----------------------------------------------------------------------------
module aecf_back import aecf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       q_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_apdu_byte,
  output logic       out_end_of_command,
  output logic       out_final_command,
  output logic       out_error_status,
  output logic       out_last_of_run
);

  typedef enum logic [3:0] {
    ST_CLA, ST_INS, ST_P1, ST_P2, ST_LC0, ST_LCH, ST_LCL,
    ST_DATA, ST_LEH, ST_LEL, ST_ERR
  } step_t;

  step_t      step_r, cur, nxt;
  logic       mid_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       eoc_r, fin_r, err_r, lor_r;

  logic [7:0] byte_c;
  logic       eoc_c, done, advance;

  // current step of the head job
  always_comb begin
    if (mid_r) begin
      cur = step_r;
    end else if (head.err) begin
      cur = ST_ERR;
    end else if (head.hdr) begin
      cur = ST_CLA;
    end else begin
      cur = ST_DATA;
    end
  end

  // byte of the step and the step after it
  always_comb begin
    byte_c = P_ZERO;
    eoc_c  = 1'b0;
    done   = 1'b0;
    nxt    = ST_CLA;
    case (cur)
      ST_CLA: begin
        byte_c = head.fin ? CLA_LAST : CLA_CHAINED;
        nxt    = ST_INS;
      end
      ST_INS: begin
        byte_c = INS_ENVELOPE;
        nxt    = ST_P1;
      end
      ST_P1: begin
        nxt = ST_P2;
      end
      ST_P2: begin
        nxt = head.ext ? ST_LC0 : ST_LCL;
      end
      ST_LC0: begin
        nxt = ST_LCH;
      end
      ST_LCH: begin
        byte_c = head.frag[15:8];
        nxt    = ST_LCL;
      end
      ST_LCL: begin
        byte_c = head.frag[7:0];
        nxt    = ST_DATA;
      end
      ST_DATA: begin
        byte_c = head.data;
        eoc_c  = head.closing && !head.fin;
        if (head.closing && head.fin) begin
          nxt = head.ext ? ST_LEH : ST_LEL;
        end else begin
          done = 1'b1;
        end
      end
      ST_LEH: begin
        byte_c = head.le_code[15:8];
        nxt    = ST_LEL;
      end
      ST_LEL: begin
        byte_c = head.le_code[7:0];
        eoc_c  = 1'b1;
        done   = 1'b1;
      end
      ST_ERR: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign advance = !q_empty && (!out_valid_r || !out_stall);
  assign pop     = advance && done;

  // step state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mid_r       <= 1'b0;
      step_r      <= ST_CLA;
    end else if (advance) begin
      out_valid_r <= 1'b1;
      mid_r       <= !done;
      step_r      <= nxt;
      byte_r      <= byte_c;
      eoc_r       <= eoc_c;
      fin_r       <= head.fin && (cur != ST_ERR);
      err_r       <= (cur == ST_ERR);
      lor_r       <= done;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_apdu_byte      = byte_r;
  assign out_end_of_command = eoc_r;
  assign out_final_command  = fin_r;
  assign out_error_status   = err_r;
  assign out_last_of_run    = lor_r;

endmodule

// ===== hdl/apdu_envelope_chain_framer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apdu_envelope_chain_framer_top
// Cuts a byte stream into chained ENVELOPE command APDUs.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one message byte per item with the total message length.
//   out_* : command bytes, one per item, last_of_run marks the final byte
//           produced by one input item.
//   cfg_* : register writes (index, data), always ready; write only while
//           the block is idle.
// Path: an accepted item enters the queue storage, then its bytes the output register.
// Throughput: the back end emits one byte per cycle while out_stall is low
//   and a job is queued. A byte opening a command follows CLA, INS, P1, P2,
//   Lc (a zero byte and a two-byte Lc when extended); the byte closing the
//   last command precedes Le (two bytes when extended). The queue of
//   QUEUE_DEPTH jobs lets input continue while headers are emitted; in_stall
//   is raised only when the queue is full.
// Reset: synchronous rst_n clears offset, fragment state, queue and the
//   output valid; registers return to 255 / 256 / extended off.
// Stall: out_stall holds the output register; the queue fills and then
//   in_stall rises.
// ----------------------------------------------------------------------------
module apdu_envelope_chain_framer_top import aecf_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic [15:0] in_message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_apdu_byte,
  output logic        out_end_of_command,
  output logic        out_final_command,
  output logic        out_error_status,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  cfg_t cfg_r;
  job_t wr_job, rd_job;
  logic push, pop, q_empty, q_full;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_fragment_bytes      <= 16'd255;
      cfg_r.expected_response_bytes <= 17'd256;
      cfg_r.extended_allowed        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_FRAGMENT:  cfg_r.max_fragment_bytes      <= cfg_data[15:0];
        CFG_EXPECTED_RESP: cfg_r.expected_response_bytes <= cfg_data;
        CFG_EXT_ALLOWED:   cfg_r.extended_allowed        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  aecf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_message_byte   (in_message_byte),
    .in_message_length (in_message_length),
    .cfg               (cfg_r),
    .q_full            (q_full),
    .push              (push),
    .job               (wr_job)
  );

  aecf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .empty  (q_empty),
    .full   (q_full)
  );

  aecf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (rd_job),
    .q_empty            (q_empty),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_apdu_byte      (out_apdu_byte),
    .out_end_of_command (out_end_of_command),
    .out_final_command  (out_final_command),
    .out_error_status   (out_error_status),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

// ===== hdl/aecf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aecf_checker
// Port-level checks of the framer, bound to the top level.
// ----------------------------------------------------------------------------
module aecf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_apdu_byte,
  input logic       out_end_of_command,
  input logic       out_final_command,
  input logic       out_error_status,
  input logic       out_last_of_run
);

  // reset empties the output
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled item stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_apdu_byte) && $stable(out_last_of_run))
    else $error("stalled output item changed");

  // error item stands alone with a zero byte
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_status |->
      out_last_of_run && !out_end_of_command && !out_final_command &&
      (out_apdu_byte == 8'h00))
    else $error("malformed error item");

  // closing byte of the last command ends the run
  a_final_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_command && out_final_command |-> out_last_of_run)
    else $error("final command closed before the end of the run");

endmodule

bind apdu_envelope_chain_framer_top aecf_checker u_aecf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_apdu_byte      (out_apdu_byte),
  .out_end_of_command (out_end_of_command),
  .out_final_command  (out_final_command),
  .out_error_status   (out_error_status),
  .out_last_of_run    (out_last_of_run)
);
